/* rtl/core/smqb_pkg.sv */
package smqb_pkg;

	localparam int NUM_TRACKS_DEF   = 16;
	localparam int NUM_SEGMENTS_DEF = 32;
	localparam int SEG_DEPTH_DEF    = 64;
	localparam int HANDLE_W         = 32;
	localparam int TRACK_W          = 4;
	localparam int FUNC_W           = 3;
	localparam int STATUS_W         = 2;
	localparam int DEPTH_CFG_W      = 7;

	localparam logic [DEPTH_CFG_W-1:0] DEPTH_RST = 7'd64;

	localparam logic [FUNC_W-1:0] FN_PUSH  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_ADD   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_FLUSH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [TRACK_W-1:0]  track;
		logic [HANDLE_W-1:0] packet_handle;
	} op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] packet_out;
		logic                track_has_data;
	} result_t;

	typedef struct packed {
		logic                ld;
		logic                claim;
		logic                seg_head;
		logic                mod_ld;
		logic                mod_sel;
		logic                push_wr;
		logic                rd_req;
		logic                pop_cap;
		logic                fl_init;
		logic                fl_step;
		logic                fl_end;
		logic                set_st;
		logic [STATUS_W-1:0] st;
		logic                resp;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              trk_ok;
		logic              known;
		logic              need_new;
		logic              free_ok;
		logic              has_data;
		logic              mod_busy;
		logic              fl_done;
	} stat_t;

endpackage

/* rtl/core/smqb_ram.sv */
module smqb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/core/smqb_mod.sv */
module smqb_mod #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         ld,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic [W-1:0] rem
);
	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     num_q;
	logic [W-1:0]     den_q;
	logic [W-1:0]     rem_q;
	logic [W:0]       shifted;
	logic [W:0]       diff;

	assign shifted = {rem_q, num_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign busy    = (cnt_q != '0);
	assign rem     = rem_q;

	// restoring remainder, one numerator bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ld) begin
			cnt_q <= CNT_W'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= num_q << 1;
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= shifted[W-1:0];
			end
		end
	end
endmodule

/* rtl/core/smqb_ctrl.sv */
module smqb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  smqb_pkg::stat_t stat,
	output smqb_pkg::cmd_t  cmd
);
	import smqb_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECIDE = 4'd1;
	localparam logic [3:0] S_PLDA   = 4'd2;
	localparam logic [3:0] S_PRUNA  = 4'd3;
	localparam logic [3:0] S_PRUNB  = 4'd4;
	localparam logic [3:0] S_QLD    = 4'd5;
	localparam logic [3:0] S_QRUN   = 4'd6;
	localparam logic [3:0] S_QCAP   = 4'd7;
	localparam logic [3:0] S_FLUSH  = 4'd8;
	localparam logic [3:0] S_RESP   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.ld   = 1'b1;
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.set_st = 1'b1;
				cmd.st     = ST_MISS;
				state_nx   = S_RESP;
				if (stat.trk_ok) begin
					unique case (stat.func)
						FN_ADD: begin
							if (stat.known) begin
								cmd.st = ST_OK;
							end else if (!stat.free_ok) begin
								cmd.st = ST_FULL;
							end else begin
								cmd.claim = 1'b1;
								cmd.st    = ST_OK;
							end
						end
						FN_PUSH: begin
							if (stat.need_new && !stat.free_ok) begin
								cmd.st = ST_FULL;
							end else begin
								cmd.claim  = 1'b1;
								cmd.set_st = 1'b0;
								state_nx   = S_PLDA;
							end
						end
						FN_POP, FN_PEEK: begin
							if (stat.has_data) begin
								cmd.seg_head = 1'b1;
								cmd.set_st   = 1'b0;
								state_nx     = S_QLD;
							end
						end
						FN_FLUSH: begin
							if (stat.known) begin
								cmd.fl_init = 1'b1;
								cmd.set_st  = 1'b0;
								state_nx    = S_FLUSH;
							end
						end
						default: begin
							cmd.st = ST_MISS;
						end
					endcase
				end
			end
			S_PLDA: begin
				cmd.mod_ld = 1'b1;
				state_nx   = S_PRUNA;
			end
			S_PRUNA: begin
				if (!stat.mod_busy) begin
					cmd.mod_ld  = 1'b1;
					cmd.mod_sel = 1'b1;
					state_nx    = S_PRUNB;
				end
			end
			S_PRUNB: begin
				if (!stat.mod_busy) begin
					cmd.push_wr = 1'b1;
					cmd.set_st  = 1'b1;
					cmd.st      = ST_OK;
					state_nx    = S_RESP;
				end
			end
			S_QLD: begin
				cmd.mod_ld = 1'b1;
				state_nx   = S_QRUN;
			end
			S_QRUN: begin
				if (!stat.mod_busy) begin
					cmd.rd_req = 1'b1;
					state_nx   = S_QCAP;
				end
			end
			S_QCAP: begin
				cmd.pop_cap = 1'b1;
				cmd.set_st  = 1'b1;
				cmd.st      = ST_OK;
				state_nx    = S_RESP;
			end
			S_FLUSH: begin
				if (stat.fl_done) begin
					cmd.fl_end = 1'b1;
					cmd.set_st = 1'b1;
					cmd.st     = ST_OK;
					state_nx   = S_RESP;
				end else begin
					cmd.fl_step = 1'b1;
				end
			end
			S_RESP: begin
				cmd.resp = 1'b1;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end
endmodule

/* rtl/core/smqb_dp.sv */
module smqb_dp #(
	parameter int NUM_TRACKS   = 16,
	parameter int NUM_SEGMENTS = 32,
	parameter int SEG_DEPTH    = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smqb_pkg::op_t                        op,
	input  logic                                 depth_we,
	input  logic [smqb_pkg::DEPTH_CFG_W-1:0]     depth_wdata,
	input  smqb_pkg::cmd_t                       cmd,
	output smqb_pkg::stat_t                      stat,
	output logic                                 done,
	output smqb_pkg::result_t                    result
);
	import smqb_pkg::*;

	localparam int TRK_N = (NUM_TRACKS < (2 ** TRACK_W)) ? NUM_TRACKS : (2 ** TRACK_W);
	localparam int TIW   = (TRK_N > 1) ? $clog2(TRK_N) : 1;
	localparam int SW    = $clog2(NUM_SEGMENTS);
	localparam int CW    = $clog2(NUM_SEGMENTS + 1);
	localparam int FW    = $clog2(SEG_DEPTH + 1);
	localparam int PW    = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
	localparam int MW    = FW + 1;
	localparam int AW    = SW + PW;

	logic [DEPTH_CFG_W-1:0] depth_q;
	logic [FW-1:0]          depth;

	logic [FUNC_W-1:0]   func_q;
	logic [TRACK_W-1:0]  track_q;
	logic [HANDLE_W-1:0] pkt_q;
	logic [HANDLE_W-1:0] pout_q;
	logic [STATUS_W-1:0] st_q;
	logic [SW-1:0]       seg_q;
	logic [CW-1:0]       iter_q;
	logic                done_q;
	result_t             res_q;

	logic          known_q [TRK_N];
	logic [CW-1:0] count_q [TRK_N];
	logic [SW-1:0] head_q  [TRK_N];
	logic [SW-1:0] tail_q  [TRK_N];

	logic          in_use_q [NUM_SEGMENTS];
	logic [FW-1:0] fill_q   [NUM_SEGMENTS];
	logic [PW-1:0] rp_q     [NUM_SEGMENTS];
	logic [SW-1:0] next_q   [NUM_SEGMENTS];

	logic [TIW-1:0]      ti;
	logic                trk_ok;
	logic                known;
	logic                cnt_zero;
	logic                tail_full;
	logic                need_new;
	logic                has_data;
	logic                free_ok;
	logic [SW-1:0]       free_idx;
	logic                mod_busy;
	logic [MW-1:0]       mod_num;
	logic [MW-1:0]       rem;
	logic [PW-1:0]       rem_pos;
	logic [PW-1:0]       rp_nx;
	logic [AW-1:0]       ram_addr;
	logic [HANDLE_W-1:0] rdata;

	always_comb begin
		if (depth_q == '0) begin
			depth = FW'(1);
		end else if (int'(depth_q) > SEG_DEPTH) begin
			depth = FW'(SEG_DEPTH);
		end else begin
			depth = FW'(depth_q);
		end
	end

	assign ti        = track_q[TIW-1:0];
	assign trk_ok    = (int'(track_q) < TRK_N);
	assign known     = trk_ok && known_q[ti];
	assign cnt_zero  = (count_q[ti] == '0);
	assign tail_full = (fill_q[tail_q[ti]] >= depth);
	assign need_new  = !known || cnt_zero || tail_full;
	assign has_data  = known && !cnt_zero && (fill_q[head_q[ti]] != '0);

	// lowest-numbered free segment
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = NUM_SEGMENTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_ok  = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign rem_pos  = rem[PW-1:0];
	assign rp_nx    = ({{(MW-PW){1'b0}}, rem_pos} + MW'(1) == {1'b0, depth}) ? '0 :
			  rem_pos + 1'b1;
	assign mod_num  = cmd.mod_sel ? ({{(MW-PW){1'b0}}, rem_pos} + {1'b0, fill_q[seg_q]}) :
			  {{(MW-PW){1'b0}}, rp_q[seg_q]};
	assign ram_addr = {seg_q, rem_pos};

	smqb_mod #(
		.W(MW)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.ld    (cmd.mod_ld),
		.num   (mod_num),
		.den   ({1'b0, depth}),
		.busy  (mod_busy),
		.rem   (rem)
	);

	smqb_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(NUM_SEGMENTS * (2 ** PW))
	) u_store (
		.clk  (clk),
		.we   (cmd.push_wr),
		.waddr(ram_addr),
		.wdata(pkt_q),
		.re   (cmd.rd_req),
		.raddr(ram_addr),
		.rdata(rdata)
	);

	always_comb begin
		stat          = '0;
		stat.func     = func_q;
		stat.trk_ok   = trk_ok;
		stat.known    = known;
		stat.need_new = need_new;
		stat.free_ok  = free_ok;
		stat.has_data = has_data;
		stat.mod_busy = mod_busy;
		stat.fl_done  = (iter_q == count_q[ti]);
	end

	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RST;
			done_q  <= 1'b0;
			iter_q  <= '0;
			for (int i = 0; i < TRK_N; i++) begin
				known_q[i] <= 1'b0;
				count_q[i] <= '0;
			end
			for (int i = 0; i < NUM_SEGMENTS; i++) begin
				in_use_q[i] <= 1'b0;
				fill_q[i]   <= '0;
				rp_q[i]     <= '0;
			end
		end else begin
			if (depth_we) begin
				depth_q <= depth_wdata;
			end
			done_q <= cmd.resp;
			if (cmd.claim) begin
				if (func_q == FN_ADD || need_new) begin
					in_use_q[free_idx] <= 1'b1;
					fill_q[free_idx]   <= '0;
					rp_q[free_idx]     <= '0;
				end
				if (func_q == FN_ADD || !known || cnt_zero) begin
					known_q[ti] <= 1'b1;
					count_q[ti] <= CW'(1);
				end else if (need_new) begin
					count_q[ti] <= count_q[ti] + 1'b1;
				end
			end
			if (cmd.push_wr) begin
				fill_q[seg_q] <= fill_q[seg_q] + 1'b1;
			end
			if (cmd.pop_cap && func_q == FN_POP) begin
				// release the head segment once its last beat leaves
				if (fill_q[seg_q] == FW'(1)) begin
					in_use_q[seg_q] <= 1'b0;
					fill_q[seg_q]   <= '0;
					rp_q[seg_q]     <= '0;
					count_q[ti]     <= count_q[ti] - 1'b1;
				end else begin
					fill_q[seg_q] <= fill_q[seg_q] - 1'b1;
					rp_q[seg_q]   <= rp_nx;
				end
			end
			if (cmd.fl_init) begin
				iter_q <= '0;
			end
			if (cmd.fl_step) begin
				in_use_q[seg_q] <= 1'b0;
				fill_q[seg_q]   <= '0;
				rp_q[seg_q]     <= '0;
				iter_q          <= iter_q + 1'b1;
			end
			if (cmd.fl_end) begin
				known_q[ti] <= 1'b0;
				count_q[ti] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			func_q  <= op.func;
			track_q <= op.track;
			pkt_q   <= op.packet_handle;
			pout_q  <= '0;
		end
		if (cmd.claim) begin
			if (func_q == FN_ADD || !known || cnt_zero) begin
				head_q[ti] <= free_idx;
				tail_q[ti] <= free_idx;
			end else if (need_new) begin
				next_q[tail_q[ti]] <= free_idx;
				tail_q[ti]         <= free_idx;
			end
			if (func_q == FN_ADD || need_new) begin
				next_q[free_idx] <= '0;
				seg_q            <= free_idx;
			end else begin
				seg_q <= tail_q[ti];
			end
		end
		if (cmd.seg_head || cmd.fl_init) begin
			seg_q <= head_q[ti];
		end
		if (cmd.fl_step) begin
			seg_q <= next_q[seg_q];
		end
		if (cmd.pop_cap) begin
			pout_q <= rdata;
			if (func_q == FN_POP && fill_q[seg_q] == FW'(1) && count_q[ti] != CW'(1)) begin
				head_q[ti] <= next_q[seg_q];
			end
		end
		if (cmd.set_st) begin
			st_q <= cmd.st;
		end
		if (cmd.resp) begin
			res_q.status         <= st_q;
			res_q.packet_out     <= pout_q;
			res_q.track_has_data <= has_data;
		end
	end

	a_done_follows_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.resp))
		else $error("result strobe without response cycle");

	a_push_seg_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.claim && func_q == FN_PUSH) |=> in_use_q[seg_q])
		else $error("push target segment not marked used");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_cap && func_q == FN_POP) |-> (fill_q[seg_q] != '0))
		else $error("pop from empty head segment");

	a_claim_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.claim && need_new) |-> free_ok)
		else $error("segment claimed from exhausted pool");
endmodule

/* rtl/core/segmented_multi_queue_buffer_core.sv */
// Start to done: add, misses and a full pool go from decide to response; pop and peek run
// one pass of the bit-serial remainder unit, then a RAM read and capture; push runs two passes
// (one bit per cycle over the ring position), then the write; flush frees one segment a step.
// One operation at a time: busy stays high from acceptance until the result is registered.
// The result shows for one cycle on done; the receiver cannot stall it.
// arst_n clears all tracks, frees every segment and sets segment depth to 64.
module segmented_multi_queue_buffer_core #(
	parameter int NUM_TRACKS   = smqb_pkg::NUM_TRACKS_DEF,
	parameter int NUM_SEGMENTS = smqb_pkg::NUM_SEGMENTS_DEF,
	parameter int SEG_DEPTH    = smqb_pkg::SEG_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  smqb_pkg::op_t                    op,
	output logic                             busy,
	output logic                             done,
	output smqb_pkg::result_t                result,
	input  logic                             depth_we,
	input  logic [smqb_pkg::DEPTH_CFG_W-1:0] depth_wdata
);
	import smqb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	smqb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	smqb_dp #(
		.NUM_TRACKS  (NUM_TRACKS),
		.NUM_SEGMENTS(NUM_SEGMENTS),
		.SEG_DEPTH   (SEG_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.depth_we   (depth_we),
		.depth_wdata(depth_wdata),
		.cmd        (cmd),
		.stat       (stat),
		.done       (done),
		.result     (result)
	);
endmodule

/* dv/tb_segmented_multi_queue_buffer_core.sv */
module tb_segmented_multi_queue_buffer_core;
	import smqb_pkg::*;

	localparam int NTRK = 16;
	localparam int NSEG = 32;
	localparam int SDEP = 64;

	logic clk;
	logic arst_n;
	logic start;
	op_t op;
	logic busy;
	logic done;
	result_t result;
	logic depth_we;
	logic [DEPTH_CFG_W-1:0] depth_wdata;

	segmented_multi_queue_buffer_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .busy(busy),
		.done(done), .result(result), .depth_we(depth_we), .depth_wdata(depth_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state
	logic [6:0] m_depth;
	bit m_known [NTRK];
	int unsigned m_head [NTRK];
	int unsigned m_tail [NTRK];
	int unsigned m_cnt [NTRK];
	int unsigned m_next [NSEG];
	bit m_used [NSEG];
	int unsigned m_fill [NSEG];
	int unsigned m_rptr [NSEG];
	logic [31:0] m_store [NSEG*SDEP];

	result_t expected_q[$];
	int err_count;
	bit idle_on;

	function automatic int unsigned eff_depth();
		if (m_depth == 0) return 1;
		if (m_depth > SDEP) return SDEP;
		return m_depth;
	endfunction

	function automatic int unsigned lowest_free();
		for (int s = 0; s < NSEG; s++)
			if (!m_used[s]) return s;
		return NSEG;
	endfunction

	function automatic void take_seg(int unsigned s);
		m_used[s] = 1;
		m_fill[s] = 0;
		m_rptr[s] = 0;
		m_next[s] = 0;
	endfunction

	function automatic void free_seg(int unsigned s);
		m_used[s] = 0;
		m_fill[s] = 0;
		m_rptr[s] = 0;
	endfunction

	function automatic bit track_nonempty(int unsigned t);
		return m_known[t] && m_cnt[t] > 0 && m_fill[m_head[t] % NSEG] > 0;
	endfunction

	function automatic result_t predict_queue_op(op_t o);
		result_t r;
		int unsigned t, d, s, n, h, pos, cnt;
		bit failed;
		t = o.track;
		d = eff_depth();
		r.status = ST_MISS;
		r.packet_out = '0;
		failed = 0;
		case (o.func)
			FN_ADD: begin
				if (m_known[t]) r.status = ST_OK;
				else begin
					s = lowest_free();
					if (s >= NSEG) r.status = ST_FULL;
					else begin
						take_seg(s);
						m_known[t] = 1;
						m_head[t] = s;
						m_tail[t] = s;
						m_cnt[t] = 1;
						r.status = ST_OK;
					end
				end
			end
			FN_PUSH: begin
				if (!m_known[t]) begin
					s = lowest_free();
					if (s >= NSEG) failed = 1;
					else begin
						take_seg(s);
						m_known[t] = 1;
						m_head[t] = s;
						m_tail[t] = s;
						m_cnt[t] = 1;
					end
				end
				if (!failed) begin
					if (m_cnt[t] == 0) begin
						s = lowest_free();
						if (s >= NSEG) failed = 1;
						else begin
							take_seg(s);
							m_head[t] = s;
							m_tail[t] = s;
							m_cnt[t] = 1;
						end
					end else begin
						s = m_tail[t] % NSEG;
						if (m_fill[s] >= d) begin
							n = lowest_free();
							if (n >= NSEG) failed = 1;
							else begin
								take_seg(n);
								m_next[s] = n;
								m_tail[t] = n;
								m_cnt[t] = (m_cnt[t] + 1) & 63;
								s = n;
							end
						end
					end
				end
				if (failed) r.status = ST_FULL;
				else begin
					pos = ((m_rptr[s] % d) + m_fill[s]) % d;
					m_store[s*SDEP + pos] = o.packet_handle;
					m_fill[s]++;
					r.status = ST_OK;
				end
			end
			FN_POP, FN_PEEK: begin
				if (track_nonempty(t)) begin
					h = m_head[t] % NSEG;
					pos = m_rptr[h] % d;
					r.packet_out = m_store[h*SDEP + pos];
					r.status = ST_OK;
					if (o.func == FN_POP) begin
						m_rptr[h] = (pos + 1) % d;
						m_fill[h]--;
						if (m_fill[h] == 0) begin
							n = m_next[h] % NSEG;
							free_seg(h);
							m_cnt[t]--;
							if (m_cnt[t] > 0) m_head[t] = n;
						end
					end
				end
			end
			FN_FLUSH: begin
				if (m_known[t]) begin
					s = m_head[t] % NSEG;
					cnt = m_cnt[t];
					for (int i = 0; i < cnt && i < NSEG; i++) begin
						n = m_next[s] % NSEG;
						free_seg(s);
						s = n;
					end
					m_known[t] = 0;
					m_cnt[t] = 0;
					r.status = ST_OK;
				end
			end
			default: r.status = ST_MISS;
		endcase
		r.track_has_data = track_nonempty(t);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	// check every result beat against the oldest expectation
	always @(posedge clk) begin
		result_t w;
		if (arst_n && done) begin
			if (expected_q.size() == 0)
				report_mismatch("unexpected result", result.packet_out, 32'h0);
			else begin
				w = expected_q.pop_front();
				if (result.status !== w.status)
					report_mismatch("status", 32'(result.status), 32'(w.status));
				if (result.packet_out !== w.packet_out)
					report_mismatch("packet_out", result.packet_out, w.packet_out);
				if (result.track_has_data !== w.track_has_data)
					report_mismatch("track_has_data", 32'(result.track_has_data),
						32'(w.track_has_data));
			end
		end
	end

	task automatic send_op(logic [2:0] f, logic [3:0] t, logic [31:0] h);
		op_t o;
		if (idle_on)
			while ($urandom_range(99) < 25) @(posedge clk);
		o.func = f;
		o.track = t;
		o.packet_handle = h;
		start <= 1'b1;
		op <= o;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q = {expected_q, predict_queue_op(o)};
		start <= 1'b0;
		// let busy rise before the next accept check
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_depth(logic [6:0] v);
		drain();
		depth_we <= 1'b1;
		depth_wdata <= v;
		@(posedge clk);
		depth_we <= 1'b0;
		m_depth = v;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_handle();
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_op(FN_POP, 4'd0, 32'h0);
		send_op(FN_PEEK, 4'd15, 32'h0);
		send_op(FN_FLUSH, 4'd3, 32'h0);
		send_op(FN_ADD, 4'd0, 32'h0);
		send_op(FN_ADD, 4'd0, 32'h0);
		send_op(FN_PUSH, 4'd0, 32'hFFFF_FFFF);
		send_op(FN_PUSH, 4'd15, 32'h0);
		send_op(FN_PUSH, 4'd0, 32'hA5A5_5A5A);
		send_op(FN_PEEK, 4'd0, 32'h0);
		send_op(FN_POP, 4'd0, 32'h0);
		send_op(FN_POP, 4'd0, 32'h0);
		send_op(FN_POP, 4'd0, 32'h0);
		send_op(3'd5, 4'd15, 32'h1234);
		send_op(3'd6, 4'd0, 32'h0);
		send_op(3'd7, 4'd15, 32'hFFFF_FFFF);
		send_op(FN_FLUSH, 4'd15, 32'h0);
		send_op(FN_FLUSH, 4'd0, 32'h0);
	endtask

	// depth 1 so each push takes a segment; drives the pool to exhaustion
	task automatic test_pool_exhaust();
		set_depth(7'd1);
		for (int i = 0; i < 34; i++) send_op(FN_PUSH, 4'd2, $urandom);
		send_op(FN_ADD, 4'd9, 32'h0);
		send_op(FN_PUSH, 4'd9, 32'h0);
		send_op(FN_PUSH, 4'd2, 32'h0);
		for (int i = 0; i < 3; i++) send_op(FN_POP, 4'd2, 32'h0);
		send_op(FN_FLUSH, 4'd2, 32'h0);
		send_op(FN_FLUSH, 4'd9, 32'h0);
	endtask

	task automatic random_phase(int n_ops);
		int r;
		logic [3:0] t;
		for (int i = 0; i < n_ops; i++) begin
			idle_on = !(i > n_ops/3 && i < n_ops/2);
			t = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom);
			r = $urandom_range(99);
			if (r < 45) send_op(FN_PUSH, t, rand_handle());
			else if (r < 75) send_op(FN_POP, t, $urandom);
			else if (r < 85) send_op(FN_PEEK, t, $urandom);
			else if (r < 91) send_op(FN_ADD, t, $urandom);
			else if (r < 96) send_op(FN_FLUSH, t, $urandom);
			else send_op(3'($urandom_range(7)), t, $urandom);
		end
		idle_on = 1;
	endtask

	task automatic test_random_depths();
		set_depth(7'd3);
		random_phase(130);
		set_depth(7'd0);
		random_phase(60);
		set_depth(7'd64);
		random_phase(150);
		// depth above the segment size acts as the maximum
		set_depth(7'd127);
		random_phase(60);
		set_depth(7'd2);
		random_phase(90);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = '0;
		depth_we = 1'b0;
		depth_wdata = '0;
		err_count = 0;
		idle_on = 1;
		m_depth = DEPTH_RST;
		for (int i = 0; i < NTRK; i++) begin
			m_known[i] = 0;
			m_cnt[i] = 0;
			m_head[i] = 0;
			m_tail[i] = 0;
		end
		for (int i = 0; i < NSEG; i++) begin
			m_used[i] = 0;
			m_fill[i] = 0;
			m_rptr[i] = 0;
			m_next[i] = 0;
		end
		for (int i = 0; i < NSEG*SDEP; i++) m_store[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_exhaust();
		test_random_depths();
		drain();
		if (err_count == 0) $display("segmented_multi_queue_buffer_core verification clean");
		else $display("segmented_multi_queue_buffer_core verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("segmented_multi_queue_buffer_core verification failed");
		$finish;
	end
endmodule
